FILE: rtl/multi_key_integer_comparator_core_macros.svh
// Assertion macros for the comparator core.
// Define NO_ASSERTIONS to compile them out.
`ifndef MULTI_KEY_INTEGER_COMPARATOR_CORE_MACROS_SVH
`define MULTI_KEY_INTEGER_COMPARATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MKIC_ASSERT_IMP(lbl, clk, rst, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("comparator check failed");
`define MKIC_ASSERT_NEXT(lbl, clk, rst, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("comparator check failed");
`else
`define MKIC_ASSERT_IMP(lbl, clk, rst, cond, expr)
`define MKIC_ASSERT_NEXT(lbl, clk, rst, cond, expr)
`endif

`endif

FILE: rtl/mkic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mkic_pkg;

  localparam int DATA_WIDTH = 32;

  // integer square root: one result bit per iteration
  localparam int SQRT_STEPS = (DATA_WIDTH + 1) / 2;
  localparam int SQRT_TOP   = 2 * ((DATA_WIDTH - 1) / 2);

  localparam int KEY_W = (SQRT_STEPS + 2 > 8) ? SQRT_STEPS + 2 : 8;
  localparam int TRIAL_W = SQRT_STEPS + 1;

  localparam int DIGIT_BASE = 10;

  typedef enum logic [1:0] {
    MODE_DIGIT_SUM     = 2'd0,
    MODE_DIVISOR_COUNT = 2'd1,
    MODE_ASCENDING     = 2'd2,
    MODE_DESCENDING    = 2'd3
  } mode_t;

  typedef struct packed {
    logic                  done;
    logic [DATA_WIDTH-1:0] quot;
    logic [DATA_WIDTH-1:0] rem;
  } div_res_t;

  typedef struct packed {
    logic                  done;
    logic                  exact;
    logic [SQRT_STEPS-1:0] root;
  } sqrt_res_t;

  typedef struct packed {
    logic             done;
    logic [KEY_W-1:0] key;
  } key_res_t;

endpackage

`default_nettype wire

FILE: rtl/mkic_serial_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module mkic_serial_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [mkic_pkg::DATA_WIDTH-1:0] dividend,
  input  wire logic [mkic_pkg::DATA_WIDTH-1:0] divisor,
  output mkic_pkg::div_res_t                  res
);

  localparam int W     = mkic_pkg::DATA_WIDTH;
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     num;
  logic [W-1:0]     den;
  logic [W-1:0]     rem;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic             done;

  logic [W:0] shifted;
  logic [W:0] diff;
  logic       ge;

  assign shifted = {rem, num[W-1]};
  assign ge      = shifted >= {1'b0, den};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num   <= dividend;
        den   <= divisor;
        rem   <= '0;
        count <= CNT_W'(W);
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= ge ? diff[W-1:0] : shifted[W-1:0];
        num   <= {num[W-2:0], ge};
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.quot = num;
  assign res.rem  = rem;

endmodule

`default_nettype wire

FILE: rtl/mkic_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Digit-by-digit integer square root, one root bit per cycle.
module mkic_isqrt (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [mkic_pkg::DATA_WIDTH-1:0] value,
  output mkic_pkg::sqrt_res_t                 res
);

  localparam int W = mkic_pkg::DATA_WIDTH;
  localparam logic [W-1:0] BIT_START = W'(1) << mkic_pkg::SQRT_TOP;

  logic [W-1:0] x;
  logic [W-1:0] root;
  logic [W-1:0] bitr;
  logic         done;

  logic [W:0] trial;
  logic       ge;

  assign trial = {1'b0, root} + {1'b0, bitr};
  assign ge    = {1'b0, x} >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      bitr <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= value;
        root <= '0;
        bitr <= BIT_START;
      end else if (bitr != '0) begin
        if (ge) begin
          x    <= x - trial[W-1:0];
          root <= (root >> 1) + bitr;
        end else begin
          root <= root >> 1;
        end
        bitr <= bitr >> 2;
        done <= bitr == W'(1);
      end
    end
  end

  assign res.done  = done;
  assign res.exact = x == '0;   // remainder zero: perfect square
  assign res.root  = root[mkic_pkg::SQRT_STEPS-1:0];

endmodule

`default_nettype wire

FILE: rtl/mkic_key_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Sort key of one operand magnitude: decimal digit sum or divisor count.
module mkic_key_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic                           div_mode,
  input  wire logic [mkic_pkg::DATA_WIDTH-1:0] mag_in,
  output mkic_pkg::key_res_t                  res
);

  localparam int W  = mkic_pkg::DATA_WIDTH;
  localparam int KW = mkic_pkg::KEY_W;
  localparam int TW = mkic_pkg::TRIAL_W;
  localparam int SW = mkic_pkg::SQRT_STEPS;

  typedef enum logic [1:0] {
    K_IDLE,
    K_DS_WAIT,
    K_SQ_WAIT,
    K_DV_WAIT
  } kstate_t;

  kstate_t      state;
  logic         dmode;
  logic [W-1:0] cur;
  logic [KW-1:0] key;
  logic [SW-1:0] root;
  logic [TW-1:0] trial;
  logic         div_go;
  logic         sq_go;
  logic         done;

  mkic_pkg::div_res_t  div_res;
  mkic_pkg::sqrt_res_t sq_res;
  logic [W-1:0]        divisor;

  assign divisor = dmode ? W'(trial) : W'(mkic_pkg::DIGIT_BASE);

  mkic_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (cur),
    .divisor  (divisor),
    .res      (div_res)
  );

  mkic_isqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_go),
    .value (cur),
    .res   (sq_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= K_IDLE;
      div_go <= 1'b0;
      sq_go  <= 1'b0;
      done   <= 1'b0;
    end else begin
      div_go <= 1'b0;
      sq_go  <= 1'b0;
      done   <= 1'b0;
      case (state)
        K_IDLE: begin
          if (start) begin
            dmode <= div_mode;
            cur   <= mag_in;
            key   <= '0;
            if (!div_mode) begin
              if (mag_in == '0) begin
                done <= 1'b1;
              end else begin
                div_go <= 1'b1;
                state  <= K_DS_WAIT;
              end
            end else if (mag_in < W'(3)) begin
              // 0, 1 and 2 count as themselves
              key  <= KW'(mag_in[1:0]);
              done <= 1'b1;
            end else begin
              sq_go <= 1'b1;
              state <= K_SQ_WAIT;
            end
          end
        end
        K_DS_WAIT: begin
          if (div_res.done) begin
            key <= key + KW'(div_res.rem[3:0]);
            if (div_res.quot == '0) begin
              done  <= 1'b1;
              state <= K_IDLE;
            end else begin
              cur    <= div_res.quot;
              div_go <= 1'b1;
            end
          end
        end
        K_SQ_WAIT: begin
          if (sq_res.done) begin
            root  <= sq_res.root;
            key   <= sq_res.exact ? KW'(1) : KW'(2);
            trial <= TW'(2);
            if (sq_res.root < SW'(2)) begin
              done  <= 1'b1;
              state <= K_IDLE;
            end else begin
              div_go <= 1'b1;
              state  <= K_DV_WAIT;
            end
          end
        end
        K_DV_WAIT: begin
          if (div_res.done) begin
            if (div_res.rem == '0) begin
              key <= key + KW'(2);
            end
            if (trial == {1'b0, root}) begin
              done  <= 1'b1;
              state <= K_IDLE;
            end else begin
              trial  <= trial + TW'(1);
              div_go <= 1'b1;
            end
          end
        end
        default: state <= K_IDLE;
      endcase
    end
  end

  assign res.done = done;
  assign res.key  = key;

endmodule

`default_nettype wire

FILE: rtl/multi_key_integer_comparator_core.sv
// Value modes compare the signed operands directly. Digit sum mode divides the
// magnitude by DIGIT_BASE once per digit; divisor mode counts magnitudes below 3 as
// themselves, else takes r = isqrt(|v|) and divides bit-serially by each of 2 to r.
// One request at a time: req_stall stays high until the previous result is registered.
// Reset (rst, synchronous): compare mode digit sum, no result pending, idle.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_key_integer_comparator_core_macros.svh"

module multi_key_integer_comparator_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wen,
  input  wire logic [1:0]                     cfg_wdata,
  input  wire logic                           req_valid,
  output logic                                req_stall,
  input  wire logic [mkic_pkg::DATA_WIDTH-1:0] first_value,
  input  wire logic [mkic_pkg::DATA_WIDTH-1:0] second_value,
  output logic                                rsp_valid,
  input  wire logic                           rsp_stall,
  output logic                                first_orders_before
);

  localparam int W = mkic_pkg::DATA_WIDTH;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t          state;
  mkic_pkg::mode_t mode;
  logic            key_mode;
  logic            val_before;
  logic            done_a;
  logic            done_b;

  logic         accept;
  logic         key_req;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic         asc;
  logic         desc;

  mkic_pkg::key_res_t key_a;
  mkic_pkg::key_res_t key_b;

  // most negative value wraps to unsigned 2^(W-1)
  function automatic logic [W-1:0] magnitude(input logic [W-1:0] v);
    magnitude = v[W-1] ? (~v + W'(1)) : v;
  endfunction

  assign req_stall = state != S_IDLE;
  assign accept    = req_valid && !req_stall;
  assign key_req   = accept &&
                     (mode == mkic_pkg::MODE_DIGIT_SUM || mode == mkic_pkg::MODE_DIVISOR_COUNT);
  assign mag_a     = magnitude(first_value);
  assign mag_b     = magnitude(second_value);
  assign asc       = $signed(first_value) < $signed(second_value);
  assign desc      = $signed(second_value) < $signed(first_value);

  mkic_key_unit u_key_a (
    .clk      (clk),
    .rst      (rst),
    .start    (key_req),
    .div_mode (mode == mkic_pkg::MODE_DIVISOR_COUNT),
    .mag_in   (mag_a),
    .res      (key_a)
  );

  mkic_key_unit u_key_b (
    .clk      (clk),
    .rst      (rst),
    .start    (key_req),
    .div_mode (mode == mkic_pkg::MODE_DIVISOR_COUNT),
    .mag_in   (mag_b),
    .res      (key_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= mkic_pkg::MODE_DIGIT_SUM;
      rsp_valid <= 1'b0;
      done_a    <= 1'b0;
      done_b    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        mode <= mkic_pkg::mode_t'(cfg_wdata);
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            key_mode   <= key_req;
            val_before <= (mode == mkic_pkg::MODE_DESCENDING) ? desc : asc;
            done_a     <= !key_req;
            done_b     <= !key_req;
            state      <= S_RUN;
          end
        end
        S_RUN: begin
          if (key_a.done) begin
            done_a <= 1'b1;
          end
          if (key_b.done) begin
            done_b <= 1'b1;
          end
          // hold the result here while the output register is occupied and stalled
          if (done_a && done_b && (!rsp_valid || !rsp_stall)) begin
            rsp_valid           <= 1'b1;
            first_orders_before <= key_mode ? (key_a.key < key_b.key) : val_before;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MKIC_ASSERT_NEXT(a_accept_busy, clk, rst, accept, req_stall)
  `MKIC_ASSERT_IMP(a_no_key_done_idle, clk, rst, state == S_IDLE, !(key_a.done || key_b.done))
  `MKIC_ASSERT_NEXT(a_value_mode_ready, clk, rst, accept && !key_req, done_a && done_b)

endmodule

`default_nettype wire

FILE: tb/sv/multi_key_integer_comparator_core_test.sv
`timescale 1ns / 1ps

module multi_key_integer_comparator_core_test;

  localparam int DW = mkic_pkg::DATA_WIDTH;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [DW-1:0] a;
    logic [DW-1:0] b;
  } operand_pair_t;

  typedef struct packed {
    operand_pair_t   pair;
    mkic_pkg::mode_t mode;
    logic            outcome;
  } verdict_t;

  logic          clk;
  logic          rst;
  logic          cfg_wen;
  logic [1:0]    cfg_wdata;
  logic          req_valid;
  logic          req_stall;
  logic [DW-1:0] first_value;
  logic [DW-1:0] second_value;
  logic          rsp_valid;
  logic          rsp_stall;
  logic          first_orders_before;

  multi_key_integer_comparator_core dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_wen             (cfg_wen),
    .cfg_wdata           (cfg_wdata),
    .req_valid           (req_valid),
    .req_stall           (req_stall),
    .first_value         (first_value),
    .second_value        (second_value),
    .rsp_valid           (rsp_valid),
    .rsp_stall           (rsp_stall),
    .first_orders_before (first_orders_before)
  );

  operand_pair_t   pairs_waiting[$];
  verdict_t        verdicts_due[$];
  operand_pair_t   next_pair;
  verdict_t        due;
  mkic_pkg::mode_t active_mode;
  logic            req_taken;
  logic            steady;
  int              send_gap;
  int              stall_left;
  int              hold_left;
  int              hold_asked;
  int              hold_served;
  int              queued_count;
  int              accepted_count;
  int              error_count;
  int              cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned magnitude_of(logic [DW-1:0] v);
    longint unsigned x;
    x = v;
    if (v[DW-1]) x = (64'd1 << DW) - x;
    return x;
  endfunction

  function automatic longint unsigned digit_total(longint unsigned m);
    longint unsigned s;
    s = 0;
    while (m != 0) begin
      s += m % mkic_pkg::DIGIT_BASE;
      m /= mkic_pkg::DIGIT_BASE;
    end
    return s;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned m);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int i = DW / 2; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= m) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned divisor_total(longint unsigned m);
    longint unsigned root;
    longint unsigned cnt;
    if (m < 3) return m;
    root = root_floor(m);
    cnt = (root * root == m) ? 1 : 2;
    for (longint unsigned d = 2; d <= root; d++)
      if (m % d == 0) cnt += 2;
    return cnt;
  endfunction

  function automatic logic predict_before(mkic_pkg::mode_t m, logic [DW-1:0] a,
                                          logic [DW-1:0] b);
    case (m)
      mkic_pkg::MODE_DIGIT_SUM:
        return digit_total(magnitude_of(a)) < digit_total(magnitude_of(b));
      mkic_pkg::MODE_DIVISOR_COUNT:
        return divisor_total(magnitude_of(a)) < divisor_total(magnitude_of(b));
      mkic_pkg::MODE_ASCENDING:
        return $signed(a) < $signed(b);
      default:
        return $signed(b) < $signed(a);
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DW-1:0] draw_operand(mkic_pkg::mode_t m);
    int unsigned   r;
    int unsigned   k;
    logic [DW-1:0] v;
    r = $urandom_range(0, 99);
    if (m == mkic_pkg::MODE_DIVISOR_COUNT) begin
      // keep trial division short: most magnitudes small, a rare one up to 2^20
      if (r < 5) v = $urandom_range(0, 1 << 20);
      else if (r < 20) begin
        k = $urandom_range(0, 64);
        v = k * k;
      end else if (r < 30) v = $urandom_range(0, 2);
      else v = $urandom_range(0, 4095);
      if ($urandom_range(0, 1)) v = -v;
    end else if (r < 10) begin
      case ($urandom_range(0, 4))
        0:       v = {1'b1, {(DW-1){1'b0}}};
        1:       v = {1'b0, {(DW-1){1'b1}}};
        2:       v = '0;
        3:       v = '1;
        default: v = 1;
      endcase
    end else if (r < 30) v = $urandom_range(0, 200) - 100;
    else v = $urandom;
    return v;
  endfunction

  task automatic queue_pair(logic [DW-1:0] a, logic [DW-1:0] b);
    operand_pair_t p;
    p.a = a;
    p.b = b;
    pairs_waiting.insert(pairs_waiting.size(), p);
    queued_count++;
  endtask

  task automatic wait_idle();
    while (!(accepted_count == queued_count && verdicts_due.size() == 0))
      @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic set_mode(mkic_pkg::mode_t m);
    wait_idle();
    cfg_wen <= 1'b1;
    cfg_wdata <= m;
    active_mode = m;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};

  initial begin
    mkic_pkg::mode_t rand_modes[10];
    logic [DW-1:0]   a;
    logic [DW-1:0]   b;
    rand_modes = '{mkic_pkg::MODE_DESCENDING, mkic_pkg::MODE_DIVISOR_COUNT,
                   mkic_pkg::MODE_DIGIT_SUM, mkic_pkg::MODE_ASCENDING,
                   mkic_pkg::MODE_DIVISOR_COUNT, mkic_pkg::MODE_DESCENDING,
                   mkic_pkg::MODE_DIGIT_SUM, mkic_pkg::MODE_DIVISOR_COUNT,
                   mkic_pkg::MODE_ASCENDING, mkic_pkg::MODE_DIGIT_SUM};
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    active_mode = mkic_pkg::MODE_DIGIT_SUM;
    steady = 1'b0;
    hold_asked = 0;
    queued_count = 0;
    accepted_count = 0;
    error_count = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // digit sum straight out of reset, no write yet
    queue_pair(0, 1);
    queue_pair(MOST_NEG, MOST_POS);
    queue_pair(MOST_POS, MOST_NEG);
    queue_pair(-19, 91);
    queue_pair(123, -124);
    queue_pair(999999999, 1000000000);

    set_mode(mkic_pkg::MODE_ASCENDING);
    hold_asked++;    // result side holds off while requests keep coming
    queue_pair(MOST_NEG, MOST_POS);
    queue_pair(MOST_POS, MOST_NEG);
    queue_pair(5, 5);
    queue_pair(-1, 0);
    queue_pair(0, -1);

    set_mode(mkic_pkg::MODE_DESCENDING);
    queue_pair(MOST_NEG, MOST_POS);
    queue_pair(MOST_POS, MOST_NEG);
    queue_pair(7, 7);
    queue_pair(-1, 0);

    set_mode(mkic_pkg::MODE_DIVISOR_COUNT);
    queue_pair(0, 1);
    queue_pair(1, 2);
    queue_pair(2, 3);
    queue_pair(3, 4);
    queue_pair(16, 15);
    queue_pair(-36, 12);
    queue_pair(-7, -7);
    queue_pair(0, -1);
    queue_pair(49, 50);

    for (int ph = 0; ph < 10; ph++) begin
      set_mode(rand_modes[ph]);
      steady = (ph == 3);
      if (ph == 5) hold_asked++;
      for (int i = 0; i < 8; i++) begin
        a = draw_operand(rand_modes[ph]);
        case ($urandom_range(0, 9))
          0:       b = a;
          1:       b = -a;    // same magnitude, opposite sign unless a is zero or the most negative value
          default: b = draw_operand(rand_modes[ph]);
        endcase
        queue_pair(a, b);
      end
    end

    wait_idle();
    repeat (50) @(negedge clk);
    if (error_count == 0 && verdicts_due.size() == 0) begin
      $display("PASS multi_key_integer_comparator_core");
    end else begin
      $display("FAIL multi_key_integer_comparator_core");
    end
    $finish;
  end

  // ---------------------------------------------------------------- request driver

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      first_value <= '0;
      second_value <= '0;
      send_gap <= 0;
    end else if (!req_valid || req_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req_valid <= 1'b0;
      end else if (pairs_waiting.size() > 0) begin
        next_pair = pairs_waiting.pop_front();
        req_valid <= 1'b1;
        first_value <= next_pair.a;
        second_value <= next_pair.b;
        send_gap <= steady ? 0 : draw_gap();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- result stall

  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_served <= 0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES - 1;
      rsp_stall <= 1'b1;
    end else if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      rsp_stall <= 1'b0;
      stall_left <= steady ? 0 : draw_gap();
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    req_taken <= !rst && req_valid && !req_stall;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        due.pair.a = first_value;
        due.pair.b = second_value;
        due.mode = active_mode;
        due.outcome = predict_before(active_mode, first_value, second_value);
        verdicts_due.insert(verdicts_due.size(), due);
        accepted_count++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (verdicts_due.size() == 0) begin
          if (error_count < MAX_REPORTS)
            $display("unexpected result %b with no request outstanding", first_orders_before);
          error_count++;
        end else begin
          due = verdicts_due.pop_front();
          if (first_orders_before !== due.outcome) begin
            if (error_count < MAX_REPORTS)
              $display("mismatch mode %s a=%0d b=%0d: expected %b, got %b", due.mode.name(),
                       $signed(due.pair.a), $signed(due.pair.b), due.outcome,
                       first_orders_before);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("FAIL multi_key_integer_comparator_core");
        $finish;
      end
    end
  end

endmodule

FILE: multi_key_integer_comparator_core.f
+incdir+rtl
rtl/mkic_pkg.sv
rtl/mkic_serial_div.sv
rtl/mkic_isqrt.sv
rtl/mkic_key_unit.sv
rtl/multi_key_integer_comparator_core.sv
tb/sv/multi_key_integer_comparator_core_test.sv
